/* design/hpdd_pkg.sv */
package hpdd_pkg;

  localparam int unsigned RegW          = 20;
  localparam int unsigned TimerBitsDef  = 20;
  localparam int unsigned CfgIdxW       = 2;

  localparam logic [RegW-1:0] IrqMinRst   = RegW'(250);
  localparam logic [RegW-1:0] LevelMinRst = RegW'(2000);

  typedef enum logic [1:0] {
    EV_LOW  = 2'd0,
    EV_HIGH = 2'd1,
    EV_IRQ  = 2'd2
  } hpdd_event_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DETECT_ENABLE = 2'd0,
    REG_IRQ_MIN       = 2'd1,
    REG_LEVEL_MIN     = 2'd2
  } hpdd_reg_e;

  typedef struct packed {
    logic            enable;
    logic [RegW-1:0] irq_min;
    logic [RegW-1:0] level_min;
  } hpdd_cfg_t;

endpackage

/* design/hpdd_core.sv */
module hpdd_core #(
  parameter int unsigned TIMER_BITS = 20
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic               line_i,
  input  logic               dp_i,
  input  logic               clr_i,
  input  hpdd_pkg::hpdd_cfg_t cfg_i,
  output logic               ev_valid_o,
  output hpdd_pkg::hpdd_event_e ev_o
);
  import hpdd_pkg::*;

  localparam int unsigned CmpW = (TIMER_BITS > RegW) ? TIMER_BITS : RegW;

  logic                  line_last_q, line_last_d;
  logic                  acc_q, acc_d;
  logic [TIMER_BITS-1:0] ticks_q, ticks_d;
  logic                  pend_q, pend_d;
  logic [RegW-1:0]       cnt_q, cnt_d;

  logic [TIMER_BITS-1:0] delta;
  logic [CmpW-1:0]       delta_x, irq_x, lvl_x;

  assign delta   = (ticks_q == '1) ? ticks_q : ticks_q + 1'b1;
  assign delta_x = CmpW'(delta);
  assign irq_x   = CmpW'(cfg_i.irq_min);
  assign lvl_x   = CmpW'(cfg_i.level_min);

  always_comb begin
    line_last_d = line_last_q;
    acc_d       = acc_q;
    ticks_d     = ticks_q;
    pend_d      = pend_q;
    cnt_d       = cnt_q;
    ev_valid_o  = 1'b0;
    ev_o        = EV_LOW;
    if (clr_i) begin
      ticks_d = '0;
      pend_d  = 1'b0;
      cnt_d   = '0;
    end else if (step_i) begin
      if (!cfg_i.enable) begin
        line_last_d = line_i;
        acc_d       = line_i;
        ticks_d     = '0;
        pend_d      = 1'b0;
        cnt_d       = '0;
      end else if (line_i != line_last_q) begin
        line_last_d = line_i;
        ticks_d     = '0;
        pend_d      = 1'b0;
        cnt_d       = '0;
        if (delta_x >= irq_x) begin
          if (!acc_q && line_i && (delta_x < lvl_x)) begin
            ev_valid_o = dp_i;
            ev_o       = EV_IRQ;
          end else if (delta_x >= lvl_x) begin
            pend_d = 1'b1;
            cnt_d  = cfg_i.level_min;
          end
          acc_d = line_i;
        end
      end else begin
        ticks_d = delta;
        if (pend_q) begin
          if (cnt_q <= RegW'(1)) begin
            pend_d     = 1'b0;
            cnt_d      = '0;
            ev_valid_o = (line_i == acc_q) && dp_i;
            ev_o       = line_i ? EV_HIGH : EV_LOW;
          end else begin
            cnt_d = cnt_q - 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_last_q <= 1'b0;
      acc_q       <= 1'b0;
      ticks_q     <= '0;
      pend_q      <= 1'b0;
      cnt_q       <= '0;
    end else begin
      line_last_q <= line_last_d;
      acc_q       <= acc_d;
      ticks_q     <= ticks_d;
      pend_q      <= pend_d;
      cnt_q       <= cnt_d;
    end
  end

endmodule

/* design/hotplug_detect_debounce_top.sv */
// Channel | Direction | Beat                              | Handshake
// in      | input     | hpd_line_i, dp_mode_active_i      | in_valid_i / in_ready_o
// out     | output    | hpd_event_o                       | out_valid_o / out_ready_i
// cfg     | input     | cfg_index_i, cfg_data_i           | cfg_valid_i / cfg_ready_o
//
// One input beat per cycle unless in_ready_o is low; a beat's event is registered for out.
// Debounce state updates in the accepting cycle; one event register plus one skid entry.
// in_ready_o drops only while both the event register and the skid entry hold beats.
// cfg_ready_o is always high. Reset: detection off, irq minimum 250, level minimum 2000,
// all debounce state zero, no events held.
module hotplug_detect_debounce_top #(
  parameter int unsigned TIMER_BITS = hpdd_pkg::TimerBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        hpd_line_i,
  input  logic                        dp_mode_active_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  hpd_event_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [hpdd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [hpdd_pkg::RegW-1:0]   cfg_data_i
);
  import hpdd_pkg::*;

  hpdd_cfg_t   cfg_q, cfg_d;
  logic        clr;
  logic        accept;
  logic        ev_valid;
  hpdd_event_e ev;

  logic        out_valid_q, out_valid_d;
  hpdd_event_e out_ev_q, out_ev_d;
  logic        skid_valid_q, skid_valid_d;
  hpdd_event_e skid_ev_q, skid_ev_d;
  logic        pop;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !skid_valid_q;
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    clr   = 1'b0;
    if (cfg_valid_i) begin
      unique case (hpdd_reg_e'(cfg_index_i))
        REG_DETECT_ENABLE: begin
          cfg_d.enable = cfg_data_i[0];
          clr          = !cfg_data_i[0];
        end
        REG_IRQ_MIN:   cfg_d.irq_min   = cfg_data_i;
        REG_LEVEL_MIN: cfg_d.level_min = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable    <= 1'b0;
      cfg_q.irq_min   <= IrqMinRst;
      cfg_q.level_min <= LevelMinRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  hpdd_core #(
    .TIMER_BITS(TIMER_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (accept),
    .line_i     (hpd_line_i),
    .dp_i       (dp_mode_active_i),
    .clr_i      (clr),
    .cfg_i      (cfg_q),
    .ev_valid_o (ev_valid),
    .ev_o       (ev)
  );

  assign pop = out_valid_q && out_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_ev_d     = out_ev_q;
    skid_valid_d = skid_valid_q;
    skid_ev_d    = skid_ev_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_ev_d     = skid_ev_q;
        skid_valid_d = 1'b0;
      end
    end else if (ev_valid) begin
      if (out_valid_q && !pop) begin
        skid_valid_d = 1'b1;
        skid_ev_d    = ev;
      end else begin
        out_valid_d = 1'b1;
        out_ev_d    = ev;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_ev_q  <= out_ev_d;
    skid_ev_q <= skid_ev_d;
  end

  assign out_valid_o = out_valid_q;
  assign hpd_event_o = out_ev_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without event register");

  a_event_needs_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid |-> (accept && dp_mode_active_i && cfg_q.enable))
    else $error("event without accepted beat in DisplayPort mode");

  a_stalled_event_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(out_ev_q)))
    else $error("stalled event dropped or changed");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !out_ready_i) |=> skid_valid_q)
    else $error("skid entry lost while stalled");

endmodule
